@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the modular exponentiation core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check on every rising clock edge, reset cycles included.
`define MEXP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

// Check on every rising clock edge while out of reset.
`define MEXP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`else

`define MEXP_ASSERT_ALWAYS(label, prop, msg)
`define MEXP_ASSERT(label, prop, msg)

`endif

`endif

@@ sv/mexp_pkg.sv @@
// Types of the modular exponentiation core: sequencer states.
package mexp_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,     // wait for an input transaction
    S_REDUCE,   // reduce the base modulo the modulus, one bit a cycle
    S_FIND,     // shift the exponent up to its top set bit
    S_MUL_DBL,  // modular multiply: double the accumulator
    S_MUL_ADD,  // modular multiply: add the multiplicand
    S_DONE      // hold the result until the receiver takes it
  } state_e;

endpackage

@@ sv/modular_exponentiation_core.sv @@
// Modular exponentiation core: base^exponent mod modulus by square-and-multiply.
//
// Usage: one input transaction on the s_axis channel carries base, exponent
// and modulus; one output transaction on the m_axis channel returns
// base^exponent mod modulus. s_axis_tready is high only while the core is
// idle, so one item is worked on at a time.
// Sequence: an exponent of zero or a modulus of zero or one goes straight
// to the result. Otherwise the base is reduced modulo the modulus, the
// exponent is shifted up to its top set bit, then 2*(top bits) modular
// multiplies at most follow, each a double-and-add over the bits of its
// multiplier. The core takes no new item until its result has been handed
// off and it has returned to idle.
// All modular arithmetic runs through one shared add / compare-subtract unit
// of WIDTH+2 bits.
// The result is held in an output register with m_axis_tvalid high until
// the receiver raises m_axis_tready; a stalled receiver stalls the core.
// Reset returns the core to idle and drops any item in progress.
module modular_exponentiation_core #(
  parameter int WIDTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata, lowest bit up: base, exponent, modulus, zero pad to whole bytes
  input  logic [((3*WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata, lowest bit up: power_mod, zero pad to whole bytes
  output logic [((WIDTH+7)/8)*8-1:0]   m_axis_tdata
);

  localparam int CW      = $clog2(WIDTH);
  localparam int OUT_W   = ((WIDTH+7)/8)*8;
  localparam logic [CW-1:0] CNT_TOP = CW'(WIDTH-1);

  mexp_pkg::state_e state_q, state_d;

  logic [WIDTH-1:0] in_base, in_exponent, in_modulus;
  logic             in_acc, out_acc, in_trivial;

  logic [WIDTH-1:0] m_q, m_d;
  logic [WIDTH-1:0] e_q, e_d;
  logic [WIDTH-1:0] g_q, g_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] bsh_q, bsh_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] result_q, result_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    left_q, left_d;
  logic             sq_q, sq_d;

  logic [WIDTH-1:0] unit_x, unit_y, unit_out;
  logic             unit_cin;
  logic [WIDTH:0]   unit_sum;
  logic [WIDTH+1:0] unit_diff;

  logic need_mul, bit_step, mul_last;

  // Unpack the input transaction
  assign in_base     = s_axis_tdata[WIDTH-1:0];
  assign in_exponent = s_axis_tdata[2*WIDTH-1:WIDTH];
  assign in_modulus  = s_axis_tdata[3*WIDTH-1:2*WIDTH];
  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign out_acc     = m_axis_tvalid && m_axis_tready;
  assign in_trivial  = (in_exponent == '0) || (in_modulus <= WIDTH'(1));

  // Sequencer helpers
  assign need_mul = sq_q && e_q[WIDTH-1];
  assign bit_step = ((state_q == mexp_pkg::S_MUL_DBL) && !bsh_q[WIDTH-1]) ||
                    (state_q == mexp_pkg::S_MUL_ADD);
  assign mul_last = bit_step && (cnt_q == '0);

  // Shared unit: (x + y + cin) mod m, valid while x + y + cin < 2m
  always_comb begin
    unit_x   = acc_q;
    unit_y   = acc_q;
    unit_cin = 1'b0;
    case (state_q)
      mexp_pkg::S_REDUCE:  unit_cin = bsh_q[WIDTH-1];
      mexp_pkg::S_MUL_ADD: unit_y   = a_q;
      default:             unit_cin = 1'b0;
    endcase
  end

  assign unit_sum  = {1'b0, unit_x} + {1'b0, unit_y} + (WIDTH+1)'(unit_cin);
  assign unit_diff = {1'b0, unit_sum} - {2'b00, m_q};
  assign unit_out  = unit_diff[WIDTH+1] ? unit_sum[WIDTH-1:0] : unit_diff[WIDTH-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mexp_pkg::S_IDLE: begin
        if (in_acc) state_d = in_trivial ? mexp_pkg::S_DONE : mexp_pkg::S_REDUCE;
      end
      mexp_pkg::S_REDUCE: begin
        if (cnt_q == '0) state_d = mexp_pkg::S_FIND;
      end
      mexp_pkg::S_FIND: begin
        if (e_q[WIDTH-1]) begin
          state_d = (left_q == '0) ? mexp_pkg::S_DONE : mexp_pkg::S_MUL_DBL;
        end
      end
      mexp_pkg::S_MUL_DBL: begin
        if (bsh_q[WIDTH-1]) begin
          state_d = mexp_pkg::S_MUL_ADD;
        end else if (mul_last) begin
          state_d = (!need_mul && left_q == CW'(1)) ? mexp_pkg::S_DONE
                                                    : mexp_pkg::S_MUL_DBL;
        end
      end
      mexp_pkg::S_MUL_ADD: begin
        if (mul_last) begin
          state_d = (!need_mul && left_q == CW'(1)) ? mexp_pkg::S_DONE
                                                    : mexp_pkg::S_MUL_DBL;
        end else begin
          state_d = mexp_pkg::S_MUL_DBL;
        end
      end
      mexp_pkg::S_DONE: begin
        if (out_acc) state_d = mexp_pkg::S_IDLE;
      end
      default: state_d = mexp_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = (state_q == mexp_pkg::S_IDLE);
    m_axis_tvalid = (state_q == mexp_pkg::S_DONE);
    m_axis_tdata  = OUT_W'(result_q);
  end

  // Datapath next values
  always_comb begin
    m_d      = m_q;
    e_d      = e_q;
    g_d      = g_q;
    a_d      = a_q;
    bsh_d    = bsh_q;
    acc_d    = acc_q;
    result_d = result_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    sq_d     = sq_q;
    case (state_q)
      mexp_pkg::S_IDLE: begin
        if (in_acc) begin
          m_d    = in_modulus;
          e_d    = in_exponent;
          bsh_d  = in_base;
          acc_d  = '0;
          cnt_d  = CNT_TOP;
          left_d = CNT_TOP;
          result_d = (in_exponent == '0) ? WIDTH'(1) : '0;
        end
      end
      mexp_pkg::S_REDUCE: begin
        // Shift in one base bit and reduce
        acc_d = unit_out;
        bsh_d = bsh_q << 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) g_d = unit_out;
      end
      mexp_pkg::S_FIND: begin
        e_d = e_q << 1;
        if (e_q[WIDTH-1]) begin
          // Top bit consumed: start squaring, or finish on a one-bit exponent
          result_d = g_q;
          a_d      = g_q;
          bsh_d    = g_q;
          acc_d    = '0;
          cnt_d    = CNT_TOP;
          sq_d     = 1'b1;
        end else begin
          left_d = left_q - CW'(1);
        end
      end
      mexp_pkg::S_MUL_DBL, mexp_pkg::S_MUL_ADD: begin
        acc_d = unit_out;
        if (bit_step) begin
          bsh_d = bsh_q << 1;
          cnt_d = cnt_q - CW'(1);
        end
        if (mul_last) begin
          acc_d    = '0;
          cnt_d    = CNT_TOP;
          a_d      = unit_out;
          result_d = unit_out;
          if (need_mul) begin
            // Multiply the squared value by the reduced base
            bsh_d = g_q;
            sq_d  = 1'b0;
          end else begin
            // Advance to the next exponent bit and square
            e_d    = e_q << 1;
            left_d = left_q - CW'(1);
            bsh_d  = unit_out;
            sq_d   = 1'b1;
          end
        end
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    m_q      <= m_d;
    e_q      <= e_d;
    g_q      <= g_d;
    a_q      <= a_d;
    bsh_q    <= bsh_d;
    acc_q    <= acc_d;
    result_q <= result_d;
    cnt_q    <= cnt_d;
    left_q   <= left_d;
    sq_q     <= sq_d;
  end

`include "assert_macros.svh"

  `MEXP_ASSERT_ALWAYS(a_no_overlap, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
  `MEXP_ASSERT(a_acc_reduced, ((state_q == mexp_pkg::S_MUL_DBL) || (state_q == mexp_pkg::S_MUL_ADD)) |-> ((acc_q < m_q) && (a_q < m_q)), "accumulator not reduced")
  `MEXP_ASSERT(a_zero_exp, (s_axis_tvalid && s_axis_tready && (in_exponent == '0)) |=> (m_axis_tvalid && (result_q == WIDTH'(1))), "zero exponent must give one")

endmodule

@@ sim/mexp_checker.sv @@
// Checker for the modular exponentiation core: predicts each power and compares results.
`timescale 1ns / 1ps

module mexp_checker #(
  parameter int WIDTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  // tdata, lowest bit up: base, exponent, modulus, zero pad to whole bytes
  input  logic [((3*WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata, lowest bit up: power_mod, zero pad to whole bytes
  input  logic [((WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  output int                           mismatch_cnt_o,
  output int                           pending_o
);

  typedef logic [WIDTH-1:0]   word_t;
  typedef logic [2*WIDTH-1:0] dword_t;

  // Expected power_mod values, oldest first
  word_t power_mod_q[$];

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  // (a * b) mod m over the full double-width product
  function automatic word_t mul_mod(word_t a, word_t b, word_t m);
    dword_t prod;
    dword_t rem;
    prod = dword_t'(a) * dword_t'(b);
    rem  = prod % dword_t'(m);
    return rem[WIDTH-1:0];
  endfunction

  // base^exponent mod modulus, scanning the exponent from its top set bit
  function automatic word_t power_mod(word_t base, word_t exponent, word_t modulus);
    word_t g;
    word_t run;
    int    top;
    int    i;
    if (exponent == '0) return word_t'(1);
    if (modulus <= word_t'(1)) return '0;
    top = WIDTH - 1;
    while (top > 0 && !exponent[top]) top--;
    g   = base % modulus;
    run = g;
    for (i = top - 1; i >= 0; i--) begin
      run = mul_mod(run, run, modulus);
      if (exponent[i]) run = mul_mod(run, g, modulus);
    end
    return run;
  endfunction

  // Watch both channels; retire results before queuing new expectations
  always @(posedge clk_i) begin
    word_t got;
    word_t want;
    bit    bad;
    bit    orphan;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got    = m_axis_tdata[WIDTH-1:0];
        bad    = 1'b0;
        orphan = 1'b0;
        want   = '0;
        if (power_mod_q.size() == 0) begin
          orphan = 1'b1;
          bad    = 1'b1;
        end else begin
          want = power_mod_q.pop_front();
          bad  = (got !== want);
        end
        if (bad) begin
          if (mismatch_cnt_o < 10) begin
            if (orphan)
              $display("[%0t] result with no item outstanding: power_mod=%h", $realtime, got);
            else
              $display("[%0t] power_mod mismatch: expected %h, got %h", $realtime, want, got);
          end
          mismatch_cnt_o <= mismatch_cnt_o + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        power_mod_q.push_back(power_mod(s_axis_tdata[WIDTH-1:0],
                                        s_axis_tdata[2*WIDTH-1:WIDTH],
                                        s_axis_tdata[3*WIDTH-1:2*WIDTH]));
      end
      pending_o <= power_mod_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the modular exponentiation core: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int WIDTH    = 64;
  localparam int IN_W     = ((3*WIDTH+7)/8)*8;
  localparam int OUT_W    = ((WIDTH+7)/8)*8;
  localparam int N_RANDOM = 100;
  localparam int RX_HOLD  = 20000;
  localparam int LIMIT    = 10_000_000;

  typedef logic [WIDTH-1:0] word_t;

  localparam word_t ALL_ONES = '1;
  localparam word_t PRIME    = 64'hFFFF_FFFF_FFFF_FFC5;  // largest 64-bit prime

  logic             clk;
  logic             rst_n;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  int               mismatches;
  int               pending;
  int               cycle_cnt = 0;
  bit               rx_hold_req = 1'b0;

  modular_exponentiation_core #(
    .WIDTH(WIDTH)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  mexp_checker #(
    .WIDTH(WIDTH)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .mismatch_cnt_o(mismatches),
    .pending_o     (pending)
  );

  // Clock, 2 ns period, first rising edge at 1 ns
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("modular_exponentiation_core verification failed");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(30, 300);
    return $urandom_range(0, 3);
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Random value of random bit length, top bit set
  function automatic word_t rand_sized();
    word_t v;
    int    len;
    len = $urandom_range(1, WIDTH);
    v = rand_word() >> (WIDTH - len);
    v[len-1] = 1'b1;
    return v;
  endfunction

  // Offer one transaction, hold until taken, then maybe idle
  task automatic send_item(input word_t base, input word_t exponent, input word_t modulus);
    int g;
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({modulus, exponent, base});
    do @(posedge clk); while (!s_tready);
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_random();
    word_t b;
    word_t e;
    word_t m;
    int    pick;
    pick = $urandom_range(0, 19);
    m = (pick == 0) ? word_t'(1) : (pick == 1) ? ALL_ONES : rand_sized();
    pick = $urandom_range(0, 9);
    b = (pick == 0) ? '0 : (pick == 1) ? ALL_ONES : rand_word();
    pick = $urandom_range(0, 19);
    e = (pick == 0) ? '0 : (pick == 1) ? ALL_ONES : rand_sized();
    send_item(b, e, m);
  endtask

  // Receiver: random ready and stall stretches, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if ($urandom_range(0, 9) < 6) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 2000 : 20)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  // Sender: directed items, random items, verdict
  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    rst_n    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero and small exponents, modulus one, degenerate bases
    send_item(64'd5, '0, 64'd1);
    send_item(ALL_ONES, '0, ALL_ONES);
    send_item(ALL_ONES, ALL_ONES, 64'd1);
    send_item(64'd9, 64'd1, 64'd1);
    send_item('0, 64'd5, 64'd97);
    send_item(ALL_ONES, 64'd1, ALL_ONES);
    send_item(ALL_ONES, 64'd1, ALL_ONES - 1);
    send_item(64'd123456789, 64'd1, 64'd1000);
    send_item(ALL_ONES - 1, 64'd2, ALL_ONES);
    send_item(64'd3, 64'd3, 64'd2);
    // Full-width exponents, moduli or bases
    send_item(ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(64'd2, ALL_ONES, PRIME);
    send_item(64'd7, PRIME - 1, PRIME);
    send_item(ALL_ONES, 64'h8000_0000_0000_0000, PRIME);
    send_item(64'd3, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_001D);
    send_item(64'd1, ALL_ONES, 64'd3);
    send_item(64'hDEAD_BEEF_0BAD_F00D, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB);
    send_item(64'h8000_0000_0000_0000, 64'd2, 64'd2);

    // Hold off the receiver while items keep coming
    rx_hold_req = 1'b1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // Let the core drain completely
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send_random();
    end
    s_tvalid <= 1'b0;

    // Drain, then idle before the verdict
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("modular_exponentiation_core verification clean");
    else
      $display("modular_exponentiation_core verification failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/mexp_pkg.sv
sv/modular_exponentiation_core.sv
sim/mexp_checker.sv
sim/tb_top.sv
